// ===== rtl/core/qear_pkg.sv =====
`timescale 1ns / 1ps

package qear_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int QW_W   = 16;  // quaternion / accel component
  localparam int ACC_W  = 60;  // multiply-accumulate register
  localparam int S_W    = 34;  // doubled quaternion sums, Q28
  localparam int T_W    = 33;  // intermediate Hamilton product terms
  localparam int MA_W   = 34;  // multiplier operand A
  localparam int MB_W   = 29;  // multiplier operand B
  localparam int CW     = 37;  // CORDIC x/y datapath
  localparam int ZW     = 25;  // CORDIC angle accumulator, centidegrees Q8
  localparam int ANG_W  = 17;  // rounded angle
  localparam int SQ_W   = 57;  // isqrt radicand
  localparam int ROOT_W = 29;  // isqrt root
  localparam int PC_W   = 6;
  localparam int OUT_W  = 16;
  localparam int PITCH_W = 15;

  localparam logic [PC_W-1:0] UOP_LAST = PC_W'(34);

  typedef enum logic [1:0] {
    CMD_ACCEL  = 2'd0,
    CMD_GYRO   = 2'd1,
    CMD_ROTVEC = 2'd2,
    CMD_MAG    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    A_QW, A_QI, A_QJ, A_QK, A_T0, A_T1, A_T2, A_T3, A_SP
  } a_sel_e;

  typedef enum logic [2:0] {
    B_QW, B_QI, B_QJ, B_QK, B_AX, B_AY, B_AZ, B_SP
  } b_sel_e;

  typedef enum logic [3:0] {
    D_NONE, D_SR, D_CR, D_SP, D_SY, D_CY, D_T0, D_T1, D_T2, D_T3,
    D_RX, D_RY, D_RZ, D_SQ
  } dst_e;

  typedef enum logic [1:0] {
    ANG_ROLL, ANG_PITCH, ANG_YAW
  } ang_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_SQRT_GO, ST_SQRT_WAIT, ST_ROLL_GO, ST_ROLL_WAIT,
    ST_PITCH_GO, ST_PITCH_WAIT, ST_YAW_GO, ST_YAW_WAIT, ST_PUSH
  } state_e;

  typedef struct packed {
    a_sel_e a;
    b_sel_e b;
    logic   neg;
    logic   first;
    dst_e   dst;
  } uop_t;

  typedef struct packed {
    logic     lat_accel;
    logic     lat_quat;
    logic     mac_en;
    uop_t     uop;
    logic     sqrt_start;
    logic     cord_start;
    ang_sel_e ang_sel;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic pitch_sat;
    logic sqrt_done;
    logic cord_done;
  } dp_stat_t;

  function automatic uop_t mk(a_sel_e a, b_sel_e b, logic neg, logic first, dst_e dst);
    uop_t u;
    u.a = a;
    u.b = b;
    u.neg = neg;
    u.first = first;
    u.dst = dst;
    return u;
  endfunction

  // Microprogram: quaternion sums, Hamilton products, pitch sine squared.
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(A_QW, B_QI, 1'b0, 1'b1, D_NONE);
      6'd1:  u = mk(A_QJ, B_QK, 1'b0, 1'b0, D_SR);
      6'd2:  u = mk(A_QI, B_QI, 1'b0, 1'b1, D_NONE);
      6'd3:  u = mk(A_QJ, B_QJ, 1'b0, 1'b0, D_CR);
      6'd4:  u = mk(A_QW, B_QJ, 1'b0, 1'b1, D_NONE);
      6'd5:  u = mk(A_QK, B_QI, 1'b1, 1'b0, D_SP);
      6'd6:  u = mk(A_QW, B_QK, 1'b0, 1'b1, D_NONE);
      6'd7:  u = mk(A_QI, B_QJ, 1'b0, 1'b0, D_SY);
      6'd8:  u = mk(A_QJ, B_QJ, 1'b0, 1'b1, D_NONE);
      6'd9:  u = mk(A_QK, B_QK, 1'b0, 1'b0, D_CY);
      6'd10: u = mk(A_QI, B_AX, 1'b1, 1'b1, D_NONE);
      6'd11: u = mk(A_QJ, B_AY, 1'b1, 1'b0, D_NONE);
      6'd12: u = mk(A_QK, B_AZ, 1'b1, 1'b0, D_T0);
      6'd13: u = mk(A_QW, B_AX, 1'b0, 1'b1, D_NONE);
      6'd14: u = mk(A_QJ, B_AZ, 1'b0, 1'b0, D_NONE);
      6'd15: u = mk(A_QK, B_AY, 1'b1, 1'b0, D_T1);
      6'd16: u = mk(A_QW, B_AY, 1'b0, 1'b1, D_NONE);
      6'd17: u = mk(A_QK, B_AX, 1'b0, 1'b0, D_NONE);
      6'd18: u = mk(A_QI, B_AZ, 1'b1, 1'b0, D_T2);
      6'd19: u = mk(A_QW, B_AZ, 1'b0, 1'b1, D_NONE);
      6'd20: u = mk(A_QI, B_AY, 1'b0, 1'b0, D_NONE);
      6'd21: u = mk(A_QJ, B_AX, 1'b1, 1'b0, D_T3);
      6'd22: u = mk(A_T1, B_QW, 1'b0, 1'b1, D_NONE);
      6'd23: u = mk(A_T0, B_QI, 1'b1, 1'b0, D_NONE);
      6'd24: u = mk(A_T2, B_QK, 1'b1, 1'b0, D_NONE);
      6'd25: u = mk(A_T3, B_QJ, 1'b0, 1'b0, D_RX);
      6'd26: u = mk(A_T2, B_QW, 1'b0, 1'b1, D_NONE);
      6'd27: u = mk(A_T0, B_QJ, 1'b1, 1'b0, D_NONE);
      6'd28: u = mk(A_T3, B_QI, 1'b1, 1'b0, D_NONE);
      6'd29: u = mk(A_T1, B_QK, 1'b0, 1'b0, D_RY);
      6'd30: u = mk(A_T3, B_QW, 1'b0, 1'b1, D_NONE);
      6'd31: u = mk(A_T0, B_QK, 1'b1, 1'b0, D_NONE);
      6'd32: u = mk(A_T1, B_QJ, 1'b1, 1'b0, D_NONE);
      6'd33: u = mk(A_T2, B_QI, 1'b0, 1'b0, D_RZ);
      6'd34: u = mk(A_SP, B_SP, 1'b0, 1'b1, D_SQ);
      default: u = mk(A_QW, B_QW, 1'b0, 1'b1, D_NONE);
    endcase
    return u;
  endfunction

  // atan(2^-k) in centidegrees Q8
  function automatic logic [ZW-1:0] atan_tab(logic [4:0] k);
    logic [ZW-1:0] v;
    unique case (k)
      5'd0:  v = ZW'(1152000);
      5'd1:  v = ZW'(680065);
      5'd2:  v = ZW'(359328);
      5'd3:  v = ZW'(182400);
      5'd4:  v = ZW'(91554);
      5'd5:  v = ZW'(45822);
      5'd6:  v = ZW'(22916);
      5'd7:  v = ZW'(11459);
      5'd8:  v = ZW'(5730);
      5'd9:  v = ZW'(2865);
      5'd10: v = ZW'(1432);
      5'd11: v = ZW'(716);
      5'd12: v = ZW'(358);
      5'd13: v = ZW'(179);
      5'd14: v = ZW'(90);
      5'd15: v = ZW'(45);
      5'd16: v = ZW'(22);
      5'd17: v = ZW'(11);
      5'd18: v = ZW'(6);
      5'd19: v = ZW'(3);
      5'd20: v = ZW'(1);
      5'd21: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/qear_cordic.sv =====
`timescale 1ns / 1ps

module qear_cordic
  import qear_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [CW-1:0]    y_i,
  input  logic signed [CW-1:0]    x_i,
  output logic                    done_o,
  output logic signed [ANG_W-1:0] angle_o
);

  localparam int KW = $clog2(CORDIC_STEPS);

  logic                    busy_q, done_q;
  logic [KW-1:0]           k_q;
  logic signed [CW-1:0]    x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ZW-1:0]    z_q, z_d, z_rnd, tab;
  logic signed [ANG_W-1:0] angle_q;

  assign dx    = y_q >>> k_q;
  assign dy    = x_q >>> k_q;
  assign tab   = $signed(atan_tab(5'(k_q)));

  always_comb begin
    if (y_q > 0) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + tab;
    end else begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - tab;
    end
  end

  assign z_rnd = z_d + ZW'(128);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        k_q <= '0;
        if (x_i == '0 && y_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        k_q <= k_q + 1'b1;
        if (k_q == KW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      angle_q <= '0;
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q <= y_i;
          y_q <= -x_i;
          z_q <= ZW'(9000 * 256);
        end else begin
          x_q <= -y_i;
          y_q <= x_i;
          z_q <= -ZW'(9000 * 256);
        end
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      angle_q <= z_rnd[ZW-1:8];
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

// ===== rtl/core/qear_isqrt.sv =====
`timescale 1ns / 1ps

module qear_isqrt
  import qear_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   n_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int RW = SQ_W + 1;

  logic          busy_q, done_q;
  logic [RW-1:0] n_q, res_q, bit_q, sum, n_d, res_d;

  assign sum = res_q + bit_q;

  always_comb begin
    if (n_q >= sum) begin
      n_d   = n_q - sum;
      res_d = (res_q >> 1) + bit_q;
    end else begin
      n_d   = n_q;
      res_d = res_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= RW'(n_i);
      res_q <= '0;
      bit_q <= RW'(1) << (SQ_W - 1);
    end else if (busy_q) begin
      n_q   <= n_d;
      res_q <= res_d;
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

// ===== rtl/core/qear_datapath.sv =====
`timescale 1ns / 1ps

module qear_datapath
  import qear_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_stat_t                  stat_o,
  input  logic signed [QW_W-1:0]    vec_x_i,
  input  logic signed [QW_W-1:0]    vec_y_i,
  input  logic signed [QW_W-1:0]    vec_z_i,
  input  logic signed [QW_W-1:0]    quat_w_i,
  output logic signed [OUT_W-1:0]   roll_o,
  output logic signed [PITCH_W-1:0] pitch_o,
  output logic signed [OUT_W-1:0]   yaw_o,
  output logic signed [OUT_W-1:0]   rot_ax_o,
  output logic signed [OUT_W-1:0]   rot_ay_o,
  output logic signed [OUT_W-1:0]   rot_az_o,
  output logic                      rot_valid_o
);

  localparam logic signed [S_W-1:0] ONE_Q28 = S_W'(1) <<< 28;

  logic                      accel_seen_q;
  logic signed [QW_W-1:0]    ax_q, ay_q, az_q, qw_q, qi_q, qj_q, qk_q;
  logic signed [S_W-1:0]     sr_q, cr_q, sp_q, sy_q, cy_q, s2, c2;
  logic signed [T_W-1:0]     t0_q, t1_q, t2_q, t3_q;
  logic signed [OUT_W-1:0]   rx_q, ry_q, rz_q, rsat;
  logic [SQ_W-1:0]           sq_q;
  logic [ROOT_W-1:0]         root_q, root;
  logic signed [ACC_W-1:0]   acc_q, acc_d, rnd;
  logic signed [ACC_W-29:0]  rnd_hi;
  logic signed [MA_W-1:0]    a_op;
  logic signed [MB_W-1:0]    b_op;
  logic signed [MA_W+MB_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_t;
  logic signed [CW-1:0]      cy_in, cx_in;
  logic signed [ANG_W-1:0]   angle;
  logic                      sqrt_done, cord_done;
  logic signed [OUT_W-1:0]   roll_q, yaw_q;
  logic signed [PITCH_W-1:0] pitch_q, pitch_fin;
  logic signed [OUT_W-1:0]   roll_out_q, yaw_out_q, rx_out_q, ry_out_q, rz_out_q;
  logic signed [PITCH_W-1:0] pitch_out_q;
  logic                      rot_valid_q;

  function automatic logic signed [MA_W-1:0] ext_a(logic signed [QW_W-1:0] v);
    return MA_W'(v);
  endfunction

  function automatic logic signed [MB_W-1:0] ext_b(logic signed [QW_W-1:0] v);
    return MB_W'(v);
  endfunction

  always_comb begin
    unique case (cmd_i.uop.a)
      A_QW:    a_op = ext_a(qw_q);
      A_QI:    a_op = ext_a(qi_q);
      A_QJ:    a_op = ext_a(qj_q);
      A_QK:    a_op = ext_a(qk_q);
      A_T0:    a_op = MA_W'(t0_q);
      A_T1:    a_op = MA_W'(t1_q);
      A_T2:    a_op = MA_W'(t2_q);
      A_T3:    a_op = MA_W'(t3_q);
      A_SP:    a_op = sp_q;
      default: a_op = '0;
    endcase
    unique case (cmd_i.uop.b)
      B_QW:    b_op = ext_b(qw_q);
      B_QI:    b_op = ext_b(qi_q);
      B_QJ:    b_op = ext_b(qj_q);
      B_QK:    b_op = ext_b(qk_q);
      B_AX:    b_op = ext_b(ax_q);
      B_AY:    b_op = ext_b(ay_q);
      B_AZ:    b_op = ext_b(az_q);
      B_SP:    b_op = sp_q[MB_W-1:0];
      default: b_op = '0;
    endcase
  end

  assign prod   = a_op * b_op;
  assign prod_t = prod[ACC_W-1:0];
  assign acc_d  = (cmd_i.uop.first ? '0 : acc_q) + (cmd_i.uop.neg ? -prod_t : prod_t);

  // Q28 doubles and the 1 - 2x cosine form
  assign s2  = {acc_d[S_W-2:0], 1'b0};
  assign c2  = ONE_Q28 - s2;
  // Q36 -> Q8, round half up, saturate
  assign rnd    = acc_d + (ACC_W'(1) <<< 27);
  assign rnd_hi = $signed(rnd[ACC_W-1:28]);
  always_comb begin
    if (rnd_hi > 32'sd32767)       rsat = 16'sd32767;
    else if (rnd_hi < -32'sd32768) rsat = -16'sd32768;
    else                           rsat = rnd[28+OUT_W-1:28];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_seen_q <= 1'b0;
      ax_q <= '0;
      ay_q <= '0;
      az_q <= '0;
    end else if (cmd_i.lat_accel) begin
      accel_seen_q <= 1'b1;
      ax_q <= vec_x_i;
      ay_q <= vec_y_i;
      az_q <= vec_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_quat) begin
      qi_q <= vec_x_i;
      qj_q <= vec_y_i;
      qk_q <= vec_z_i;
      qw_q <= quat_w_i;
    end
    if (cmd_i.mac_en) begin
      acc_q <= acc_d;
      unique case (cmd_i.uop.dst)
        D_SR:    sr_q <= s2;
        D_CR:    cr_q <= c2;
        D_SP:    sp_q <= s2;
        D_SY:    sy_q <= s2;
        D_CY:    cy_q <= c2;
        D_T0:    t0_q <= acc_d[T_W-1:0];
        D_T1:    t1_q <= acc_d[T_W-1:0];
        D_T2:    t2_q <= acc_d[T_W-1:0];
        D_T3:    t3_q <= acc_d[T_W-1:0];
        D_RX:    rx_q <= rsat;
        D_RY:    ry_q <= rsat;
        D_RZ:    rz_q <= rsat;
        D_SQ:    sq_q <= (SQ_W'(1) << (SQ_W - 1)) - acc_d[SQ_W-1:0];
        default: ;
      endcase
    end
  end

  qear_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .n_i     (sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    if (sqrt_done) root_q <= root;
  end

  always_comb begin
    unique case (cmd_i.ang_sel)
      ANG_ROLL: begin
        cy_in = CW'(sr_q);
        cx_in = CW'(cr_q);
      end
      ANG_PITCH: begin
        cy_in = CW'(sp_q);
        cx_in = CW'(root_q);
      end
      ANG_YAW: begin
        cy_in = CW'(sy_q);
        cx_in = CW'(cy_q);
      end
      default: begin
        cy_in = '0;
        cx_in = '0;
      end
    endcase
  end

  qear_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cord_start),
    .y_i     (cy_in),
    .x_i     (cx_in),
    .done_o  (cord_done),
    .angle_o (angle)
  );

  function automatic logic signed [OUT_W-1:0] clamp180(logic signed [ANG_W-1:0] a);
    if (a > 17'sd18000)       return 16'sd18000;
    else if (a < -17'sd18000) return -16'sd18000;
    else                      return a[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cord_done) begin
      unique case (cmd_i.ang_sel)
        ANG_ROLL:  roll_q <= clamp180(angle);
        ANG_PITCH: begin
          if (angle > 17'sd9000)       pitch_q <= 15'sd9000;
          else if (angle < -17'sd9000) pitch_q <= -15'sd9000;
          else                         pitch_q <= angle[PITCH_W-1:0];
        end
        ANG_YAW:   yaw_q <= clamp180(angle);
        default: ;
      endcase
    end
  end

  assign stat_o.pitch_sat = (sp_q >= ONE_Q28) || (sp_q <= -ONE_Q28);
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.cord_done = cord_done;

  always_comb begin
    if (stat_o.pitch_sat) pitch_fin = sp_q[S_W-1] ? -15'sd9000 : 15'sd9000;
    else                  pitch_fin = pitch_q;
  end

  // held accel is zero until the first accel transaction, so the
  // rotated terms come out zero without gating
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      roll_out_q  <= roll_q;
      pitch_out_q <= pitch_fin;
      yaw_out_q   <= yaw_q;
      rx_out_q    <= rx_q;
      ry_out_q    <= ry_q;
      rz_out_q    <= rz_q;
      rot_valid_q <= accel_seen_q;
    end
  end

  assign roll_o      = roll_out_q;
  assign pitch_o     = pitch_out_q;
  assign yaw_o       = yaw_out_q;
  assign rot_ax_o    = rx_out_q;
  assign rot_ay_o    = ry_out_q;
  assign rot_az_o    = rz_out_q;
  assign rot_valid_o = rot_valid_q;

endmodule

// ===== rtl/core/qear_ctrl.sv =====
`timescale 1ns / 1ps

module qear_ctrl
  import qear_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic [1:0] cmd_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  dp_cmd_o,
  input  dp_stat_t dp_stat_i
);

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  logic            accept, out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        pc_d = '0;
        if (accept && cmd_e'(cmd_i) == CMD_ROTVEC) state_d = ST_MAC;
      end
      ST_MAC: begin
        pc_d = pc_q + 1'b1;
        if (pc_q == UOP_LAST) begin
          state_d = dp_stat_i.pitch_sat ? ST_ROLL_GO : ST_SQRT_GO;
        end
      end
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (dp_stat_i.sqrt_done) state_d = ST_ROLL_GO;
      ST_ROLL_GO:   state_d = ST_ROLL_WAIT;
      ST_ROLL_WAIT: begin
        if (dp_stat_i.cord_done) begin
          state_d = dp_stat_i.pitch_sat ? ST_YAW_GO : ST_PITCH_GO;
        end
      end
      ST_PITCH_GO:   state_d = ST_PITCH_WAIT;
      ST_PITCH_WAIT: if (dp_stat_i.cord_done) state_d = ST_YAW_GO;
      ST_YAW_GO:     state_d = ST_YAW_WAIT;
      ST_YAW_WAIT:   if (dp_stat_i.cord_done) state_d = ST_PUSH;
      ST_PUSH:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o            = '0;
    dp_cmd_o.uop        = ucode(pc_q);
    dp_cmd_o.ang_sel    = ANG_ROLL;
    dp_cmd_o.lat_accel  = accept && cmd_e'(cmd_i) == CMD_ACCEL;
    dp_cmd_o.lat_quat   = accept && cmd_e'(cmd_i) == CMD_ROTVEC;
    dp_cmd_o.mac_en     = state_q == ST_MAC;
    dp_cmd_o.sqrt_start = state_q == ST_SQRT_GO;
    dp_cmd_o.cord_start = (state_q == ST_ROLL_GO) || (state_q == ST_PITCH_GO) ||
                          (state_q == ST_YAW_GO);
    if (state_q == ST_PITCH_GO || state_q == ST_PITCH_WAIT) begin
      dp_cmd_o.ang_sel = ANG_PITCH;
    end else if (state_q == ST_YAW_GO || state_q == ST_YAW_WAIT) begin
      dp_cmd_o.ang_sel = ANG_YAW;
    end
    dp_cmd_o.load_out   = (state_q == ST_PUSH) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.load_out)         out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/quat_euler_accel_rotate.sv =====
`timescale 1ns / 1ps

// Orientation event processor. Accelerometer transactions (cmd 0) latch a
// Q8 acceleration; gyro (1) and magnetometer (3) transactions are absorbed
// with no result. A rotation vector transaction (cmd 2, Q1.14 quaternion)
// yields one result: roll, pitch, yaw in centidegrees (CORDIC atan2,
// pitch via sqrt(1 - s^2) and clamped to +-90 deg once |s| reaches one)
// plus the latched acceleration rotated by q*v*conj(q), rounded and
// saturated to Q8; rot_valid is set once any acceleration was latched.
// A non-rotation transaction does not stall the input. A rotation vector
// transaction runs 35 multiply-accumulate steps on the single shared
// 34x29 multiplier, 29 bit-pair steps of the integer square root, then
// three sequential runs of the one CORDIC unit. The sqrt and the pitch
// CORDIC run are skipped when pitch saturates. Input stays stalled until
// the result enters the output register; that register holds it until
// the sink takes it.

module quat_euler_accel_rotate
  import qear_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic signed [QW_W-1:0]    vec_x_i,
  input  logic signed [QW_W-1:0]    vec_y_i,
  input  logic signed [QW_W-1:0]    vec_z_i,
  input  logic signed [QW_W-1:0]    quat_w_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [OUT_W-1:0]   roll_o,
  output logic signed [PITCH_W-1:0] pitch_o,
  output logic signed [OUT_W-1:0]   yaw_o,
  output logic signed [OUT_W-1:0]   rot_ax_o,
  output logic signed [OUT_W-1:0]   rot_ay_o,
  output logic signed [OUT_W-1:0]   rot_az_o,
  output logic                      rot_valid_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: accept, microprogram, unit starts, output handshake
  qear_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  // MAC, isqrt, CORDIC and the output register
  qear_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .quat_w_i    (quat_w_i),
    .roll_o      (roll_o),
    .pitch_o     (pitch_o),
    .yaw_o       (yaw_o),
    .rot_ax_o    (rot_ax_o),
    .rot_ay_o    (rot_ay_o),
    .rot_az_o    (rot_az_o),
    .rot_valid_o (rot_valid_o)
  );

endmodule

// ===== bench/qear_checker.sv =====
`timescale 1ns / 1ps

module qear_checker
  import qear_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [1:0]                cmd_i,
  input  logic signed [QW_W-1:0]    vec_x_i,
  input  logic signed [QW_W-1:0]    vec_y_i,
  input  logic signed [QW_W-1:0]    vec_z_i,
  input  logic signed [QW_W-1:0]    quat_w_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [OUT_W-1:0]   roll_i,
  input  logic signed [PITCH_W-1:0] pitch_i,
  input  logic signed [OUT_W-1:0]   yaw_i,
  input  logic signed [OUT_W-1:0]   rot_ax_i,
  input  logic signed [OUT_W-1:0]   rot_ay_i,
  input  logic signed [OUT_W-1:0]   rot_az_i,
  input  logic                      rot_valid_i,
  output int                        errors_o,
  output int                        pending_o
);

  typedef struct packed {
    logic signed [OUT_W-1:0]   roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [OUT_W-1:0]   yaw;
    logic signed [OUT_W-1:0]   ax;
    logic signed [OUT_W-1:0]   ay;
    logic signed [OUT_W-1:0]   az;
    logic                      rv;
  } attitude_t;

  attitude_t     attitude_q[$];
  longint        acc_x, acc_y, acc_z;
  bit            acc_held;
  int            errors;

  localparam longint ONE_Q28 = 64'sd1 << 28;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint angle_cdeg(longint y, longint x);
    longint z, t, dx, dy;
    int steps;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 9000 * 256;
      end else begin
        t = x; x = -y; y = t; z = -9000 * 256;
      end
    end
    steps = CORDIC_STEPS_DEF < 24 ? CORDIC_STEPS_DEF : 24;
    for (int k = 0; k < steps; k++) begin
      dx = floor_shr(y, k);
      dy = floor_shr(x, k);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_tab(5'(k)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_tab(5'(k)));
      end
    end
    return floor_shr(z + 128, 8);
  endfunction

  function automatic longint round_q36(longint v);
    return clip(floor_shr(v + (64'sd1 <<< 27), 28), -32768, 32767);
  endfunction

  function automatic attitude_t orient(longint qw, longint qi, longint qj, longint qk);
    attitude_t r;
    longint s, co, m, t0, t1, t2, t3;
    s = 2 * (qw * qi + qj * qk);
    co = ONE_Q28 - 2 * (qi * qi + qj * qj);
    r.roll = OUT_W'(clip(angle_cdeg(s, co), -18000, 18000));
    s = 2 * (qw * qj - qk * qi);
    m = s < 0 ? -s : s;
    if (m >= ONE_Q28) r.pitch = s < 0 ? -15'sd9000 : 15'sd9000;
    else r.pitch = PITCH_W'(clip(angle_cdeg(s,
                     root_floor((64'd1 << 56) - longint'(s * s))), -9000, 9000));
    s = 2 * (qw * qk + qi * qj);
    co = ONE_Q28 - 2 * (qj * qj + qk * qk);
    r.yaw = OUT_W'(clip(angle_cdeg(s, co), -18000, 18000));
    r.ax = '0; r.ay = '0; r.az = '0;
    r.rv = acc_held;
    if (acc_held) begin
      t0 = -qi * acc_x - qj * acc_y - qk * acc_z;
      t1 = qw * acc_x + qj * acc_z - qk * acc_y;
      t2 = qw * acc_y + qk * acc_x - qi * acc_z;
      t3 = qw * acc_z + qi * acc_y - qj * acc_x;
      r.ax = OUT_W'(round_q36(t1 * qw - t0 * qi - t2 * qk + t3 * qj));
      r.ay = OUT_W'(round_q36(t2 * qw - t0 * qj - t3 * qi + t1 * qk));
      r.az = OUT_W'(round_q36(t3 * qw - t0 * qk - t1 * qj + t2 * qi));
    end
    return r;
  endfunction

  assign errors_o  = errors;
  assign pending_o = attitude_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    attitude_t want, got;
    if (!rst_ni) begin
      attitude_q.delete();
      acc_x = 0; acc_y = 0; acc_z = 0;
      acc_held = 0;
      errors = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{roll_i, pitch_i, yaw_i, rot_ax_i, rot_ay_i, rot_az_i, rot_valid_i};
        if (attitude_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = attitude_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (cmd_e'(cmd_i))
          CMD_ACCEL: begin
            acc_x = vec_x_i; acc_y = vec_y_i; acc_z = vec_z_i;
            acc_held = 1;
          end
          CMD_ROTVEC: attitude_q.push_back(orient(quat_w_i, vec_x_i, vec_y_i, vec_z_i));
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Drives sensor event transactions into the attitude block; the checker
// beside it predicts every rotation vector result and counts mismatches.
module tb;
  import qear_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] cmd = CMD_MAG;
  logic signed [QW_W-1:0] vx = 0, vy = 0, vz = 0, qw = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [OUT_W-1:0] roll, yaw, rax, ray, raz;
  logic signed [PITCH_W-1:0] pitch;
  logic rot_valid;
  int errors, pending;

  // idle rates in percent per phase
  int src_idle = 26, snk_idle = 48;
  bit hold_sink = 0;
  bit stim_done = 0;
  int quiet = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  quat_euler_accel_rotate uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .vec_x_i(vx), .vec_y_i(vy), .vec_z_i(vz), .quat_w_i(qw),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .roll_o(roll), .pitch_o(pitch), .yaw_o(yaw),
    .rot_ax_o(rax), .rot_ay_o(ray), .rot_az_o(raz), .rot_valid_o(rot_valid)
  );

  qear_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .vec_x_i(vx), .vec_y_i(vy), .vec_z_i(vz), .quat_w_i(qw),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .roll_i(roll), .pitch_i(pitch), .yaw_i(yaw),
    .rot_ax_i(rax), .rot_ay_i(ray), .rot_az_i(raz), .rot_valid_i(rot_valid),
    .errors_o(errors), .pending_o(pending)
  );

  // sink: random stalls, or a long hold-off while hold_sink is set
  always @(posedge clk_i)
    out_stall <= hold_sink || ($urandom_range(99) < snk_idle);

  // long receiver hold-off, counted here
  initial begin
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    hold_sink = 1;
    repeat (600) @(posedge clk_i);
    hold_sink = 0;
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one transaction; a random gap before it keeps valid low
  task automatic send(logic [1:0] c, logic [15:0] x, logic [15:0] y,
                      logic [15:0] z, logic [15:0] w = '0);
    if ($urandom_range(99) < src_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid <= 1;
    cmd <= c; vx <= x; vy <= y; vz <= z; qw <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // random, unnormalised quaternion with random sign pattern and axis weighting
  task automatic send_quat();
    int a, b, c, d, m;
    a = $urandom_range(16384); b = $urandom_range(16384);
    c = $urandom_range(16384); d = $urandom_range(16384);
    m = $urandom_range(3);
    if (m == 0) b = 0;
    if (m == 1) begin a = $urandom_range(50); c = $urandom_range(50); end
    send(CMD_ROTVEC, $urandom_range(1) ? -b : b, $urandom_range(1) ? -c : c,
         $urandom_range(1) ? -d : d, $urandom_range(1) ? -a : a);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: rotation before any accel, extremes, gimbal lock, zero quat
    send(CMD_ROTVEC, 0, 0, 0, 16384);
    send(CMD_ROTVEC, 0, 0, 0, 0);
    send(CMD_GYRO, 16'h7fff, 16'h8000, 16'h5555, 16'haaaa);
    send(CMD_MAG, 16'h8000, 16'h7fff, 16'haaaa, 16'h5555);
    send(CMD_ACCEL, 0, 0, 2511);
    send(CMD_ROTVEC, 0, 0, 0, 16384);
    send(CMD_ROTVEC, 16384, 0, 0, 0);
    send(CMD_ROTVEC, 0, 16384, 0, 0);
    send(CMD_ROTVEC, 0, 0, 16384, 0);
    send(CMD_ROTVEC, 0, 11585, 0, 11585);
    send(CMD_ROTVEC, 0, -11585, 0, 11585);
    send(CMD_ROTVEC, 0, 11600, 0, 11600);
    send(CMD_ROTVEC, -16384, 0, 0, 0);
    send(CMD_ROTVEC, 0, 0, 0, -16384);
    send(CMD_ACCEL, 16'h7fff, 16'h8000, 16'h7fff);
    send(CMD_ROTVEC, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send(CMD_ROTVEC, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send(CMD_ROTVEC, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    send(CMD_ACCEL, 16'h8000, 16'h8000, 16'h8000);
    send(CMD_ROTVEC, 5000, -7000, 3000, 12000);
    for (int phase = 0; phase < 3; phase++) begin
      src_idle = phase == 0 ? 26 : (phase == 1 ? 48 : 0);
      snk_idle = phase == 0 ? 48 : (phase == 1 ? 26 : 0);
      for (int n = 0; n < 280; n++) begin
        case ($urandom_range(9))
          0, 1: send(CMD_ACCEL, $urandom, $urandom, $urandom);
          2: send(CMD_GYRO, $urandom, $urandom, $urandom, $urandom);
          3: send(CMD_MAG, $urandom, $urandom, $urandom, $urandom);
          4: send(CMD_ROTVEC, $urandom, $urandom, $urandom, $urandom);
          default: send_quat();
        endcase
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
